>>> hdl/dqv_pkg.sv
// ----------------------------------------------------------------------------
// dqv_pkg
// Shared types and constants for the bounded deque with delete by value.
// ----------------------------------------------------------------------------
`default_nettype none

package dqv_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int OCNT_W = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_PREPEND    = 3'd1,
    CMD_POP_HEAD   = 3'd2,
    CMD_POP_TAIL   = 3'd3,
    CMD_REMOVE_VAL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RD_HEAD,
    S_RD_TAIL,
    S_WB,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              empty_flag;
    logic [DATA_W-1:0] tail_value;
    logic [DATA_W-1:0] head_value;
    logic [OCNT_W-1:0] entry_count;
    status_e           status;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/dqv_ram.sv
// ----------------------------------------------------------------------------
// dqv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dqv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/dqv_addr.sv
// ----------------------------------------------------------------------------
// dqv_addr
// Shared circular address adder: physical slot = (head + offset) mod DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module dqv_addr (
  input  wire logic [dqv_pkg::PTR_W-1:0] base,
  input  wire logic [dqv_pkg::PTR_W-1:0] offset,
  output      logic [dqv_pkg::PTR_W-1:0] phys
);

  localparam logic [dqv_pkg::PTR_W:0] DEPTH_X = (dqv_pkg::PTR_W + 1)'(dqv_pkg::DEPTH);

  logic [dqv_pkg::PTR_W:0] sum;
  logic [dqv_pkg::PTR_W:0] wrapped;

  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = sum - DEPTH_X;
    if (sum >= DEPTH_X) begin
      phys = wrapped[dqv_pkg::PTR_W-1:0];
    end else begin
      phys = sum[dqv_pkg::PTR_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dqv_seq.sv
// ----------------------------------------------------------------------------
// dqv_seq
// Command sequencer: pointer/count update, search scan, gap close, readback.
// ----------------------------------------------------------------------------
`default_nettype none

module dqv_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_fire,
  input  wire logic [dqv_pkg::CMD_W-1:0]     in_command,
  input  wire logic [dqv_pkg::DATA_W-1:0]    in_value,
  output      logic                          in_ready,
  input  wire logic                          out_free,
  output      logic                          res_valid,
  output      dqv_pkg::result_t              res,
  output      logic [dqv_pkg::PTR_W-1:0]     head,
  output      logic [dqv_pkg::PTR_W-1:0]     offset,
  input  wire logic [dqv_pkg::PTR_W-1:0]     phys,
  output      logic                          ram_we,
  output      logic [dqv_pkg::PTR_W-1:0]     ram_waddr,
  output      logic [dqv_pkg::DATA_W-1:0]    ram_wdata,
  input  wire logic [dqv_pkg::DATA_W-1:0]    ram_rdata
);

  localparam logic [dqv_pkg::CNT_W-1:0] CNT_ONE  = dqv_pkg::CNT_W'(1);
  localparam logic [dqv_pkg::CNT_W-1:0] CNT_FULL = dqv_pkg::CNT_W'(dqv_pkg::DEPTH);
  localparam logic [dqv_pkg::PTR_W-1:0] OFF_LAST = dqv_pkg::PTR_W'(dqv_pkg::DEPTH - 1);
  localparam logic [dqv_pkg::PTR_W-1:0] OFF_ONE  = dqv_pkg::PTR_W'(1);

  dqv_pkg::state_e              state, state_next;
  dqv_pkg::cmd_e                cmd_q;
  dqv_pkg::status_e             status_q;
  logic [dqv_pkg::DATA_W-1:0]   val_q;
  logic [dqv_pkg::CNT_W-1:0]    count;
  logic [dqv_pkg::CNT_W-1:0]    idx;
  logic                         rv;
  logic [dqv_pkg::PTR_W-1:0]    raddr_q;
  logic [dqv_pkg::PTR_W-1:0]    waddr_q;
  logic [dqv_pkg::DATA_W-1:0]   head_q;
  logic [dqv_pkg::DATA_W-1:0]   tail_q;

  logic                         full;
  logic                         empty;
  logic                         idx_live;
  logic                         match;
  logic [dqv_pkg::CNT_W-1:0]    last_pos;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign idx_live = (idx < count);
  assign match    = rv && (ram_rdata == val_q);
  assign last_pos = count - CNT_ONE;
  assign in_ready = (state == dqv_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    offset     = '0;
    ram_we     = 1'b0;
    ram_waddr  = phys;
    ram_wdata  = val_q;
    res_valid  = 1'b0;
    case (state)
      dqv_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = dqv_pkg::S_EXEC;
        end
      end
      dqv_pkg::S_EXEC: begin
        state_next = dqv_pkg::S_RD_HEAD;
        case (cmd_q)
          dqv_pkg::CMD_APPEND: begin
            offset = count[dqv_pkg::PTR_W-1:0];
            ram_we = !full;
          end
          dqv_pkg::CMD_PREPEND: begin
            offset = OFF_LAST;
            ram_we = !full;
          end
          dqv_pkg::CMD_POP_HEAD: begin
            offset = OFF_ONE;
          end
          dqv_pkg::CMD_REMOVE_VAL: begin
            if (!empty) begin
              state_next = dqv_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      dqv_pkg::S_SCAN: begin
        offset = idx_live ? idx[dqv_pkg::PTR_W-1:0] : '0;
        if (match) begin
          state_next = dqv_pkg::S_SHIFT;
        end else if (!rv) begin
          state_next = dqv_pkg::S_RD_HEAD;
        end
      end
      dqv_pkg::S_SHIFT: begin
        offset    = idx_live ? idx[dqv_pkg::PTR_W-1:0] : '0;
        ram_we    = rv;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
        if (!rv) begin
          state_next = dqv_pkg::S_RD_HEAD;
        end
      end
      dqv_pkg::S_RD_HEAD: begin
        state_next = dqv_pkg::S_RD_TAIL;
      end
      dqv_pkg::S_RD_TAIL: begin
        offset     = empty ? '0 : last_pos[dqv_pkg::PTR_W-1:0];
        state_next = dqv_pkg::S_WB;
      end
      dqv_pkg::S_WB: begin
        state_next = dqv_pkg::S_OUT;
      end
      dqv_pkg::S_OUT: begin
        res_valid = out_free;
        if (out_free) begin
          state_next = dqv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dqv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
      rv    <= 1'b0;
    end else begin
      case (state)
        dqv_pkg::S_IDLE: begin
          if (in_fire) begin
            status_q <= dqv_pkg::ST_DONE;
            idx      <= '0;
          end
        end
        dqv_pkg::S_EXEC: begin
          case (cmd_q)
            dqv_pkg::CMD_APPEND: begin
              if (full) begin
                status_q <= dqv_pkg::ST_FULL;
              end else begin
                count <= count + CNT_ONE;
              end
            end
            dqv_pkg::CMD_PREPEND: begin
              if (full) begin
                status_q <= dqv_pkg::ST_FULL;
              end else begin
                head  <= phys;
                count <= count + CNT_ONE;
              end
            end
            dqv_pkg::CMD_POP_HEAD: begin
              if (empty) begin
                status_q <= dqv_pkg::ST_EMPTY;
              end else begin
                head  <= phys;
                count <= last_pos;
              end
            end
            dqv_pkg::CMD_POP_TAIL: begin
              if (empty) begin
                status_q <= dqv_pkg::ST_EMPTY;
              end else begin
                count <= last_pos;
              end
            end
            dqv_pkg::CMD_REMOVE_VAL: begin
              if (empty) begin
                status_q <= dqv_pkg::ST_EMPTY;
              end else begin
                idx <= CNT_ONE;
                rv  <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        dqv_pkg::S_SCAN: begin
          if (idx_live) begin
            idx <= idx + CNT_ONE;
          end
          rv <= idx_live;
          if (match) begin
            waddr_q <= raddr_q;
          end else if (!rv) begin
            status_q <= dqv_pkg::ST_NOT_FOUND;
          end
        end
        dqv_pkg::S_SHIFT: begin
          if (idx_live) begin
            idx <= idx + CNT_ONE;
          end
          rv <= idx_live;
          if (rv) begin
            waddr_q <= raddr_q;
          end else begin
            count <= last_pos;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    raddr_q <= phys;
    if (in_fire) begin
      cmd_q <= dqv_pkg::cmd_e'(in_command);
      val_q <= in_value;
    end
    if (state == dqv_pkg::S_RD_TAIL) begin
      head_q <= ram_rdata;
    end
    if (state == dqv_pkg::S_WB) begin
      tail_q <= ram_rdata;
    end
  end

  always_comb begin
    res.status      = status_q;
    res.entry_count = dqv_pkg::OCNT_W'(count);
    res.empty_flag  = empty;
    res.head_value  = empty ? '0 : head_q;
    res.tail_value  = empty ? '0 : tail_q;
  end

endmodule

`default_nettype wire

>>> hdl/bounded_deque_with_value_delete_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_core
// Bounded double-ended queue of signed 32-bit values with delete by value.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ channel, one transfer per command; each command
// returns exactly one result transfer on the m_ channel with status, entry
// count, head and tail values and empty flag, all as seen after the command.
// Storage is a circular buffer in one dual-port RAM addressed through a
// single shared (head + offset) mod DEPTH adder.
// For append, prepend, pop head, pop tail, unknown codes and remove on an empty
// store the sequencer passes through its execute, head read, tail read,
// write-back and output states, and m_tvalid is registered from the output
// state. Remove by value scans from the head one entry per cycle and closes
// the gap behind a hit one entry per cycle, then reads back head and tail the
// same way. s_tready is high only while no command is in progress.
// A finished result sits in the output register; a new command is accepted
// while it waits, and that command holds in its last step until m_tready
// frees the register. Reset empties the store (count and head pointer
// cleared) and drops any pending result; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_value_delete_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  // [2:0] command, [34:3] value, [39:35] zero
  input  wire logic [dqv_pkg::IN_TDATA_W-1:0]      s_tdata,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  // [1:0] status, [6:2] entry_count, [38:7] head_value, [70:39] tail_value,
  // [71] empty_flag
  output      logic [dqv_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  logic                          in_fire;
  logic                          out_free;
  logic                          res_valid;
  dqv_pkg::result_t              res;
  logic [dqv_pkg::PTR_W-1:0]     head;
  logic [dqv_pkg::PTR_W-1:0]     offset;
  logic [dqv_pkg::PTR_W-1:0]     phys;
  logic                          ram_we;
  logic [dqv_pkg::PTR_W-1:0]     ram_waddr;
  logic [dqv_pkg::DATA_W-1:0]    ram_wdata;
  logic [dqv_pkg::DATA_W-1:0]    ram_rdata;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  dqv_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_command (s_tdata[2:0]),
    .in_value   (s_tdata[34:3]),
    .in_ready   (s_tready),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .head       (head),
    .offset     (offset),
    .phys       (phys),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  dqv_addr u_addr (
    .base   (head),
    .offset (offset),
    .phys   (phys)
  );

  dqv_ram #(
    .WIDTH (dqv_pkg::DATA_W),
    .DEPTH (dqv_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (phys),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {res.empty_flag, res.tail_value, res.head_value,
                  res.entry_count, res.status};
    end
  end

endmodule

`default_nettype wire

>>> hdl/dqv_chk.sv
// ----------------------------------------------------------------------------
// dqv_chk
// Port-level checks for the deque core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqv_chk (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [dqv_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam logic [dqv_pkg::OCNT_W-1:0] OCNT_FULL = dqv_pkg::OCNT_W'(dqv_pkg::DEPTH);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("command accepted while another is in progress");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[71] == (m_tdata[6:2] == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[71]) |-> (m_tdata[70:7] == '0))
    else $error("empty result reports nonzero head or tail");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == dqv_pkg::ST_FULL)) |-> (m_tdata[6:2] == OCNT_FULL))
    else $error("full status with store not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind bounded_deque_with_value_delete_core dqv_chk u_chk (.*);

`default_nettype wire

>>> dv/bounded_deque_with_value_delete_checker.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_checker
// Watches both stream channels of the deque core and scores its results.
// ----------------------------------------------------------------------------
// Every command transfer is run through a shadow deque, and the result it
// should produce is queued. Every result transfer is compared field by field
// with the oldest queued result. A result with nothing queued counts as a
// failure. The failure count and the number of queued results go to the top.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete_checker
  import dqv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] deque_shadow[$];
  result_t           expected_results[$];
  int                fails = 0;

  function automatic result_t apply_command(input logic [CMD_W-1:0] cmd,
                                            input logic [DATA_W-1:0] val);
    result_t r;
    int      hit;
    r.status = ST_DONE;
    hit      = -1;
    case (cmd)
      CMD_APPEND: begin
        if (deque_shadow.size() >= DEPTH) r.status = ST_FULL;
        else deque_shadow.push_back(val);
      end
      CMD_PREPEND: begin
        if (deque_shadow.size() >= DEPTH) r.status = ST_FULL;
        else deque_shadow.push_front(val);
      end
      CMD_POP_HEAD: begin
        if (deque_shadow.size() == 0) r.status = ST_EMPTY;
        else void'(deque_shadow.pop_front());
      end
      CMD_POP_TAIL: begin
        if (deque_shadow.size() == 0) r.status = ST_EMPTY;
        else void'(deque_shadow.pop_back());
      end
      CMD_REMOVE_VAL: begin
        if (deque_shadow.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < deque_shadow.size(); i++) begin
            if (hit < 0 && deque_shadow[i] == val) hit = i;
          end
          if (hit < 0) r.status = ST_NOT_FOUND;
          else deque_shadow.delete(hit);
        end
      end
      default: ;
    endcase
    r.entry_count = OCNT_W'(deque_shadow.size());
    if (deque_shadow.size() == 0) begin
      r.head_value = '0;
      r.tail_value = '0;
      r.empty_flag = 1'b1;
    end else begin
      r.head_value = deque_shadow[0];
      r.tail_value = deque_shadow[deque_shadow.size() - 1];
      r.empty_flag = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = result_t'(m_tdata);
    if (rst) begin
      deque_shadow.delete();
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_command(s_tdata[2:0], s_tdata[34:3]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
          fails = fails + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fails = fails + 1;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
            fails = fails + 1;
          end
          if (got.head_value !== want.head_value) begin
            $display("%0t: head_value expected %h got %h", $time,
                     want.head_value, got.head_value);
            fails = fails + 1;
          end
          if (got.tail_value !== want.tail_value) begin
            $display("%0t: tail_value expected %h got %h", $time,
                     want.tail_value, got.tail_value);
            fails = fails + 1;
          end
          if (got.empty_flag !== want.empty_flag) begin
            $display("%0t: empty_flag expected %0d got %0d", $time,
                     want.empty_flag, got.empty_flag);
            fails = fails + 1;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_results.size();
  end

endmodule

>>> dv/bounded_deque_with_value_delete_core_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_core_tb
// Stimulus and verdict for the bounded deque core.
// ----------------------------------------------------------------------------
// A directed pass covers empty and full stores, value extremes, duplicates,
// misses and unused command codes. Random traffic follows in phases that
// favor growth, shrinkage or balance, with values drawn mostly from a small
// pool so removes by value hit. The sender runs in bursts with gaps; the
// receiver stalls in phases of its own. The checker does all scoring.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete_core_tb;
  import dqv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     fail_count;
  int                     pending_count;

  int ready_mode = 0;
  int ready_phase_left = 0;

  bounded_deque_with_value_delete_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bounded_deque_with_value_delete_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: phases of always ready, coin flip, and mostly stalled
  always @(posedge clk) begin
    if (ready_phase_left == 0) begin
      ready_mode       <= $urandom_range(0, 2);
      ready_phase_left <= $urandom_range(20, 200);
    end else begin
      ready_phase_left <= ready_phase_left - 1;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({val, cmd});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom;
      default: return DATA_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int bias);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    roll = $urandom_range(0, 99);
    if (roll < bias) return $urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND;
    case ($urandom_range(0, 3))
      0:       return CMD_POP_HEAD;
      1:       return CMD_POP_TAIL;
      default: return CMD_REMOVE_VAL;
    endcase
  endfunction

  initial begin
    int sent;
    int burst_left;
    int bias;
    int bias_left;
    sent       = 0;
    burst_left = 0;
    bias       = 50;
    bias_left  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store
    send_cmd(CMD_POP_HEAD, 32'h0);
    send_cmd(CMD_POP_TAIL, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE_VAL, 32'h0);
    send_cmd(CMD_UNUSED_FIRST, 32'h1234_5678);
    // extremes, miss, duplicates, head and tail matches
    send_cmd(CMD_APPEND, 32'h7FFF_FFFF);
    send_cmd(CMD_PREPEND, 32'h8000_0000);
    send_cmd(CMD_UNUSED_LAST, 32'h0);
    send_cmd(CMD_REMOVE_VAL, 32'h0000_0001);
    send_cmd(CMD_APPEND, 32'h0000_0005);
    send_cmd(CMD_APPEND, 32'h0000_0005);
    send_cmd(CMD_REMOVE_VAL, 32'h0000_0005);
    send_cmd(CMD_REMOVE_VAL, 32'h8000_0000);
    send_cmd(CMD_REMOVE_VAL, 32'h0000_0005);
    send_cmd(CMD_POP_HEAD, 32'h0);
    send_cmd(CMD_POP_TAIL, 32'h0);
    // fill to capacity, then overflow both ends
    for (int i = 0; i < DEPTH; i++) begin
      if (i % 2 == 0) send_cmd(CMD_APPEND, DATA_W'(i));
      else send_cmd(CMD_PREPEND, ~DATA_W'(i));
    end
    send_cmd(CMD_APPEND, 32'hAAAA_AAAA);
    send_cmd(CMD_PREPEND, 32'h5555_5555);
    send_cmd(CMD_REMOVE_VAL, 32'h0000_0006);
    send_cmd(CMD_POP_HEAD, 32'h0);
    pause_until_drained();

    while (sent < RANDOM_ITEMS) begin
      if (bias_left == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 75;
          1:       bias = 25;
          default: bias = 50;
        endcase
        bias_left = $urandom_range(40, 100);
      end
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk);
        else @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      send_cmd(pick_cmd(bias), pick_value());
      sent++;
      bias_left--;
      burst_left--;
      if (sent % 250 == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
